// ===== sv/iirdf_pkg.sv =====
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared types and constants for the direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iirdf_pkg;

   localparam int COEF_WIDTH    = 16;
   localparam int HIST_DEPTH    = 3;
   localparam int MAX_FF_TAPS   = 4;
   localparam int MAX_FB_TAPS   = 4;
   localparam int CSR_IDX_WIDTH = 3;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   localparam coef_type FF_COEF_0_RESET = 16'sd16384;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_FF_COEF_0 = 3'd0,
      REG_FF_COEF_1 = 3'd1,
      REG_FF_COEF_2 = 3'd2,
      REG_FF_COEF_3 = 3'd3,
      REG_FB_COEF_1 = 3'd4,
      REG_FB_COEF_2 = 3'd5,
      REG_FB_COEF_3 = 3'd6
   } reg_index_type;

   typedef struct packed {
      coef_type [MAX_FF_TAPS-1:0] ff;
      coef_type [MAX_FB_TAPS-1:1] fb;
   } coef_set_type;

   typedef struct packed {
      logic s1_load;
      logic s1_sob;
      logic s2_load;
      logic s2_sob;
   } lane_ctrl_type;

endpackage

// ===== sv/iirdf_intf.sv =====
// ----------------------------------------------------------------------------
// iirdf interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iirdf_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_re;
   logic signed [SAMPLE_WIDTH-1:0] sample_im;
   logic                           start_of_block;

   modport source (output valid, output sample_re, output sample_im,
                   output start_of_block, input ready);
   modport sink   (input valid, input sample_re, input sample_im,
                   input start_of_block, output ready);
endinterface

interface iirdf_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] filtered_re;
   logic signed [SAMPLE_WIDTH-1:0] filtered_im;
   logic                           clipped;

   modport source (output valid, output filtered_re, output filtered_im,
                   output clipped, input ready);
   modport sink   (input valid, input filtered_re, input filtered_im,
                   input clipped, output ready);
endinterface

interface iirdf_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [iirdf_pkg::CSR_IDX_WIDTH-1:0]   index;
   logic [iirdf_pkg::COEF_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/iirdf_csr.sv =====
// ----------------------------------------------------------------------------
// iirdf_csr
// Coefficient register file, written through the register channel.
// ----------------------------------------------------------------------------
module iirdf_csr (
   input  logic                    clock,
   input  logic                    reset,
   iirdf_csr_if.sink               csr_chan,
   output iirdf_pkg::coef_set_type coefs
);

   // b0 at unity, every other tap zero
   localparam iirdf_pkg::coef_set_type COEFS_RESET = {
      {((iirdf_pkg::MAX_FF_TAPS-1)*iirdf_pkg::COEF_WIDTH){1'b0}},
      iirdf_pkg::FF_COEF_0_RESET,
      {((iirdf_pkg::MAX_FB_TAPS-1)*iirdf_pkg::COEF_WIDTH){1'b0}}
   };

   iirdf_pkg::coef_set_type coefs_ff;
   iirdf_pkg::coef_set_type coefs_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_chan.valid) begin
         unique case (iirdf_pkg::reg_index_type'(csr_chan.index))
            iirdf_pkg::REG_FF_COEF_0: coefs_in.ff[0] = csr_chan.data;
            iirdf_pkg::REG_FF_COEF_1: coefs_in.ff[1] = csr_chan.data;
            iirdf_pkg::REG_FF_COEF_2: coefs_in.ff[2] = csr_chan.data;
            iirdf_pkg::REG_FF_COEF_3: coefs_in.ff[3] = csr_chan.data;
            iirdf_pkg::REG_FB_COEF_1: coefs_in.fb[1] = csr_chan.data;
            iirdf_pkg::REG_FB_COEF_2: coefs_in.fb[2] = csr_chan.data;
            iirdf_pkg::REG_FB_COEF_3: coefs_in.fb[3] = csr_chan.data;
            default: coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= COEFS_RESET;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

// ===== sv/iirdf_lane.sv =====
// ----------------------------------------------------------------------------
// iirdf_lane
// One filter lane: registered feedforward sum, then feedback, rounding and
// saturation with the output history.
// ----------------------------------------------------------------------------
module iirdf_lane #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int NUM_FF_TAPS    = 4,
   parameter int NUM_FB_TAPS    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  iirdf_pkg::lane_ctrl_type       ctrl,
   input  iirdf_pkg::coef_set_type        coefs,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0] result,
   output logic                           clip
);

   localparam int PROD_W  = SAMPLE_WIDTH + iirdf_pkg::COEF_WIDTH;
   localparam int ACC_W   = (PROD_W + 3 > COEF_FRAC_BITS + 2) ? PROD_W + 3
                                                              : COEF_FRAC_BITS + 2;
   localparam int SUM_W   = (ACC_W - COEF_FRAC_BITS > SAMPLE_WIDTH)
                            ? ACC_W - COEF_FRAC_BITS : SAMPLE_WIDTH + 1;
   localparam int DEPTH   = iirdf_pkg::HIST_DEPTH;

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] MAX_Y =
      {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] MIN_Y =
      {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] x_hist_ff [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] y_hist_ff [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] x_tap     [DEPTH+1];
   logic signed [SAMPLE_WIDTH-1:0] y_tap     [DEPTH+1];
   logic signed [PROD_W-1:0]       ff_prod   [DEPTH+1];
   logic signed [PROD_W-1:0]       fb_prod   [DEPTH+1];
   logic signed [ACC_W-1:0]        ff_sum_in;
   logic signed [ACC_W-1:0]        ff_sum_ff;
   logic signed [ACC_W-1:0]        acc;
   logic signed [SUM_W-1:0]        quot;

   // stage 1: feedforward taps
   always_comb begin
      x_tap[0]  = sample;
      ff_sum_in = '0;
      for (int k = 1; k <= DEPTH; k++) begin
         x_tap[k] = ctrl.s1_sob ? '0 : x_hist_ff[k-1];
      end
      for (int k = 0; k <= DEPTH; k++) begin
         ff_prod[k] = x_tap[k] * $signed(coefs.ff[k]);
         if (k < NUM_FF_TAPS) begin
            ff_sum_in = ff_sum_in + ACC_W'(ff_prod[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            x_hist_ff[k] <= '0;
         end
      end else if (ctrl.s1_load) begin
         for (int k = 0; k < DEPTH; k++) begin
            x_hist_ff[k] <= x_tap[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         ff_sum_ff <= ff_sum_in;
      end
   end

   // stage 2: feedback taps, round half up, saturate
   always_comb begin
      y_tap[0]   = '0;
      fb_prod[0] = '0;
      acc        = ff_sum_ff + ROUND_HALF;
      for (int k = 1; k <= DEPTH; k++) begin
         y_tap[k]   = ctrl.s2_sob ? '0 : y_hist_ff[k-1];
         fb_prod[k] = y_tap[k] * $signed(coefs.fb[k]);
         if (k < NUM_FB_TAPS) begin
            acc = acc - ACC_W'(fb_prod[k]);
         end
      end
      quot = SUM_W'(acc >>> COEF_FRAC_BITS);
      clip = 1'b0;
      if (quot > MAX_Y) begin
         result = SAMPLE_WIDTH'(MAX_Y);
         clip   = 1'b1;
      end else if (quot < MIN_Y) begin
         result = SAMPLE_WIDTH'(MIN_Y);
         clip   = 1'b1;
      end else begin
         result = SAMPLE_WIDTH'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            y_hist_ff[k] <= '0;
         end
      end else if (ctrl.s2_load) begin
         y_hist_ff[0] <= result;
         for (int k = 1; k < DEPTH; k++) begin
            y_hist_ff[k] <= y_tap[k];
         end
      end
   end

endmodule

// ===== sv/iir_direct_form_filter.sv =====
// ----------------------------------------------------------------------------
// iir_direct_form_filter
// Direct-form-I IIR filter on complex samples, one lane per component.
// ----------------------------------------------------------------------------
// Takes one complex sample per clock unless the output stalls and returns
// one filtered sample per request via stage one and the output register.
// Stage one forms the feedforward sum; stage two closes the feedback loop
// (three coefficient products on the previous saturated outputs, rounding
// and saturation), which sets the one-sample-per-cycle rate. Real and
// imaginary parts run in identical lanes with shared coefficients; clipped
// is the OR of both lanes. start_of_block zeroes the history before use.
// Coefficients are Q2.14 and should be written only while the filter is idle.
module iir_direct_form_filter #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int NUM_FF_TAPS    = 4,
   parameter int NUM_FB_TAPS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   iirdf_req_if.sink   req_chan,
   iirdf_rsp_if.source rsp_chan,
   iirdf_csr_if.sink   csr_chan
);

   iirdf_pkg::coef_set_type  coefs;
   iirdf_pkg::lane_ctrl_type ctrl;

   logic                           s1_vld_ff, s1_vld_in;
   logic                           s1_sob_ff;
   logic                           out_vld_ff, out_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] out_re_ff, out_im_ff;
   logic                           out_clip_ff;
   logic signed [SAMPLE_WIDTH-1:0] lane_re, lane_im;
   logic                           clip_re, clip_im;
   logic                           s1_load, s2_load, s2_adv;

   assign s2_adv         = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_vld_ff || s2_adv;
   assign s1_load        = req_chan.valid && req_chan.ready;
   assign s2_load        = s1_vld_ff && s2_adv;
   assign s1_vld_in      = s1_load || (s1_vld_ff && !s2_adv);
   assign out_vld_in     = s2_load || (out_vld_ff && !rsp_chan.ready);

   always_comb begin
      ctrl.s1_load = s1_load;
      ctrl.s1_sob  = req_chan.start_of_block;
      ctrl.s2_load = s2_load;
      ctrl.s2_sob  = s1_sob_ff;
   end

   iirdf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .coefs    (coefs)
   );

   iirdf_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .NUM_FF_TAPS    (NUM_FF_TAPS),
      .NUM_FB_TAPS    (NUM_FB_TAPS)
   ) u_lane_re (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .coefs  (coefs),
      .sample (req_chan.sample_re),
      .result (lane_re),
      .clip   (clip_re)
   );

   iirdf_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .NUM_FF_TAPS    (NUM_FF_TAPS),
      .NUM_FB_TAPS    (NUM_FB_TAPS)
   ) u_lane_im (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .coefs  (coefs),
      .sample (req_chan.sample_im),
      .result (lane_im),
      .clip   (clip_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sob_ff <= req_chan.start_of_block;
      end
      if (s2_load) begin
         out_re_ff   <= lane_re;
         out_im_ff   <= lane_im;
         out_clip_ff <= clip_re || clip_im;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.filtered_re = out_re_ff;
   assign rsp_chan.filtered_im = out_im_ff;
   assign rsp_chan.clipped     = out_clip_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_vld_ff && out_vld_ff && !rsp_chan.ready))
      else $error("request stalled with room in the pipeline");

   a_stage_moves_on: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s2_adv) |=> out_vld_ff)
      else $error("stage one request lost on its way to the output");

   a_out_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(s1_vld_ff))
      else $error("response without a request in stage one");

endmodule
